// File: sv/random_prim_maze_generator_macros.svh
// assertion macros for the prim maze generator checker
// no dependencies
`ifndef RANDOM_PRIM_MAZE_GENERATOR_MACROS_SVH
`define RANDOM_PRIM_MAZE_GENERATOR_MACROS_SVH
// implication checked on every clock, off during reset
`define RPMG_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rpmg check failed");
// next-cycle implication
`define RPMG_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rpmg check failed");
`endif

// File: sv/rpmg_pkg.sv
// shared types and constants of the prim maze generator
// no dependencies
`default_nettype none
package rpmg_pkg;
  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_COLS_DEF = 32;
  localparam int FRONTIER_DEPTH_DEF = 256;
  localparam logic [5:0] ROWS_RESET = 6'd21;
  localparam logic [5:0] COLS_RESET = 6'd31;
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;
  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_STEP = 1'b1;
  localparam logic CELL_WALL = 1'b0;
  localparam logic CELL_OPEN = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] rand_frontier;
    logic [15:0] rand_neighbor;
  } in_word_t;

  typedef struct packed {
    logic [4:0] cell_row;
    logic [4:0] cell_col;
    logic       wall_valid;
    logic [4:0] wall_row;
    logic [4:0] wall_col;
    logic [8:0] pending_count;
    logic       done_res;
  } out_word_t;

  // request and answer of the shared remainder unit
  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [10:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic        done;
    logic [10:0] rem;
  } mod_rsp_t;
endpackage
`default_nettype wire

// File: sv/rpmg_mod_unit.sv
// bit-serial remainder unit, one quotient bit per cycle
// depends on rpmg_pkg
`default_nettype none
module rpmg_mod_unit
  import rpmg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mod_req_t req,
  output mod_rsp_t      rsp
);
  logic        busy_r, busy_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [15:0] dvd_r, dvd_nxt;
  logic [11:0] rem_r, rem_nxt;
  logic [10:0] dvs_r, dvs_nxt;
  logic        done_r, done_nxt;
  logic [11:0] shifted;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[10:0], dvd_r[15]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      dvd_nxt  = req.dividend;
      rem_nxt  = 12'd0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      // restoring step: shift one dividend bit in, subtract when it fits
      dvd_nxt = {dvd_r[14:0], 1'b0};
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = shifted - {1'b0, dvs_r};
      end else begin
        rem_nxt = shifted;
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r[10:0];
endmodule
`default_nettype wire

// File: sv/random_prim_maze_generator.sv
// prim maze generator: one word in, one word out; a new word is taken only when idle
// begin: map clear (MAX_ROWS*MAX_COLS), seed cell (1,1), then per neighbour a map read
//   and, for a walled one, a duplicate scan of the frontier before the append
// step: remainder picks a frontier entry, later entries shift down, four neighbours are read,
//   a second remainder picks the open neighbour, wall and cell open, then the adds
// sync active-low reset, grid 21x31
`default_nettype none
module random_prim_maze_generator
  import rpmg_pkg::*;
#(
  parameter int MAX_ROWS       = MAX_ROWS_DEF,
  parameter int MAX_COLS       = MAX_COLS_DEF,
  parameter int FRONTIER_DEPTH = FRONTIER_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_word_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_word_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [5:0] cfg_wdata
);
  localparam int MD = MAX_ROWS * MAX_COLS;
  localparam int MA = $clog2(MD);
  localparam int FA = $clog2(FRONTIER_DEPTH);
  localparam int FC = FA + 1;
  localparam int EW = 7; // room for coordinates and coordinate plus two
  localparam logic [EW-1:0] MAXR = EW'(MAX_ROWS);
  localparam logic [EW-1:0] MAXC = EW'(MAX_COLS);

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_SEED, S_MOD1, S_RD, S_RDW, S_SHIFT, S_SHW,
    S_NB_RD, S_NB_W, S_NB_EVAL, S_MOD2, S_WALL, S_OPEN,
    S_ADD_RD, S_ADD_W, S_ADD_EVAL, S_SCAN, S_SCANW, S_APPEND, S_OUT
  } state_t;

  state_t         state_r;
  logic [5:0]     rows_r, cols_r;
  logic [FC-1:0]  cnt_r;
  logic [FC-1:0]  idx_r;
  logic [MA:0]    clr_r;
  in_word_t       in_r;
  out_word_t      res_r;
  out_word_t      out_r;
  logic           out_valid_r;
  logic [EW-1:0]  cur_r_r, cur_c_r;
  logic [1:0]     dir_r;
  logic [3:0]     nbm_r;
  logic [2:0]     nbn_r;
  logic [EW-1:0]  cand_r_r, cand_c_r;

  // finished word with the frontier count after the item
  out_word_t fin_word;
  always_comb begin
    fin_word = res_r;
    fin_word.pending_count = 9'(cnt_r);
    fin_word.done_res = (cnt_r == '0);
  end

  // storage: map and frontier, one write and one read port each, registered read
  logic           map_mem [MD];
  logic           map_rd_r;
  logic [9:0]     fr_mem [FRONTIER_DEPTH];
  logic [9:0]     fr_rd_r;
  logic           map_we;
  logic [MA-1:0]  map_wa, map_ra;
  logic           map_wd;
  logic           fr_we;
  logic [FA-1:0]  fr_wa, fr_ra;
  logic [9:0]     fr_wd;

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_rd_r <= map_mem[map_ra];
    if (fr_we) fr_mem[fr_wa] <= fr_wd;
    fr_rd_r <= fr_mem[fr_ra];
  end

  // shared remainder unit
  mod_req_t mreq;
  mod_rsp_t mrsp;
  rpmg_mod_unit u_mod (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  // effective grid size
  logic [EW-1:0] eff_m, eff_n;
  always_comb begin
    eff_m = (EW'(rows_r) > MAXR) ? MAXR : EW'(rows_r);
    if (eff_m < EW'(3)) eff_m = EW'(3);
    eff_n = (EW'(cols_r) > MAXC) ? MAXC : EW'(cols_r);
    if (eff_n < EW'(3)) eff_n = EW'(3);
  end

  // neighbour in direction dir_r: left, right, up, down
  logic [EW-1:0] nb_r, nb_c;
  logic          nb_ok, nb_in_map;
  always_comb begin
    nb_r = cur_r_r;
    nb_c = cur_c_r;
    nb_ok = 1'b0;
    case (dir_r)
      2'd0: begin nb_c = cur_c_r - EW'(2); nb_ok = cur_c_r > EW'(2); end
      2'd1: begin nb_c = cur_c_r + EW'(2); nb_ok = (cur_c_r + EW'(2)) < eff_n; end
      2'd2: begin nb_r = cur_r_r - EW'(2); nb_ok = cur_r_r > EW'(2); end
      default: begin nb_r = cur_r_r + EW'(2); nb_ok = (cur_r_r + EW'(2)) < eff_m; end
    endcase
    nb_in_map = (nb_r < MAXR) && (nb_c < MAXC);
  end

  function automatic logic [MA-1:0] maddr(input logic [EW-1:0] r, input logic [EW-1:0] c);
    logic [MA+EW:0] a;
    a = (MA+EW+1)'(r) * (MA+EW+1)'(MAX_COLS) + (MA+EW+1)'(c);
    return a[MA-1:0];
  endfunction

  // selected neighbour slot from remainder
  logic [1:0] sel_dir;
  logic [2:0] seen;
  always_comb begin
    sel_dir = 2'd0;
    seen = 3'd0;
    for (int d = 0; d < 4; d++) begin
      if (nbm_r[d]) begin
        if (seen == mrsp.rem[2:0]) sel_dir = 2'(d);
        seen = seen + 3'd1;
      end
    end
  end

  logic [9:0] cand_key;
  assign cand_key = {cand_r_r[4:0], cand_c_r[4:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_r      <= ROWS_RESET;
      cols_r      <= COLS_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROWS: rows_r <= cfg_wdata;
          CFG_COLS: cols_r <= cfg_wdata;
          default: ;
        endcase
      end
      // output register: a finished word moves in once the previous one has gone
      if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
        out_r       <= fin_word;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          in_r <= in_data;
          res_r <= '0;
          if (in_data.action == ACT_BEGIN) begin
            clr_r <= '0;
            cnt_r <= '0;
            state_r <= S_CLR;
          end else if (cnt_r == '0) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_MOD1;
          end
        end
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (MA+1)'(MD - 1)) state_r <= S_SEED;
        end
        S_SEED: begin
          cur_r_r <= EW'(1);
          cur_c_r <= EW'(1);
          res_r.cell_row <= 5'd1;
          res_r.cell_col <= 5'd1;
          dir_r <= 2'd0;
          state_r <= S_ADD_RD;
        end
        S_MOD1: if (mrsp.done) begin
          idx_r <= FC'(mrsp.rem);
          state_r <= S_RD;
        end
        S_RD: state_r <= S_RDW;
        S_RDW: begin
          cur_r_r <= EW'(fr_rd_r[9:5]);
          cur_c_r <= EW'(fr_rd_r[4:0]);
          res_r.cell_row <= fr_rd_r[9:5];
          res_r.cell_col <= fr_rd_r[4:0];
          state_r <= S_SHIFT;
        end
        S_SHIFT: begin
          if (idx_r + 1'b1 >= cnt_r) begin
            cnt_r <= cnt_r - 1'b1;
            dir_r <= 2'd0;
            nbm_r <= 4'd0;
            nbn_r <= 3'd0;
            state_r <= S_NB_RD;
          end else begin
            state_r <= S_SHW;
          end
        end
        S_SHW: begin
          idx_r <= idx_r + 1'b1;
          state_r <= S_SHIFT;
        end
        S_NB_RD: state_r <= S_NB_W;
        S_NB_W: state_r <= S_NB_EVAL;
        S_NB_EVAL: begin
          if (nb_ok && nb_in_map && map_rd_r == CELL_OPEN) begin
            nbm_r[dir_r] <= 1'b1;
            nbn_r <= nbn_r + 3'd1;
          end
          dir_r <= dir_r + 2'd1;
          if (dir_r == 2'd3) state_r <= S_MOD2;
          else state_r <= S_NB_RD;
        end
        S_MOD2: begin
          if (nbn_r == 3'd0) state_r <= S_OPEN;
          else if (mrsp.done) begin
            dir_r <= sel_dir;
            state_r <= S_WALL;
          end
        end
        S_WALL: begin
          res_r.wall_valid <= 1'b1;
          res_r.wall_row <= 5'((cur_r_r + nb_r) >> 1);
          res_r.wall_col <= 5'((cur_c_r + nb_c) >> 1);
          state_r <= S_OPEN;
        end
        S_OPEN: begin
          dir_r <= 2'd0;
          state_r <= S_ADD_RD;
        end
        S_ADD_RD: state_r <= S_ADD_W;
        S_ADD_W: state_r <= S_ADD_EVAL;
        S_ADD_EVAL: begin
          if (nb_ok && nb_in_map && map_rd_r == CELL_WALL) begin
            cand_r_r <= nb_r;
            cand_c_r <= nb_c;
            idx_r <= '0;
            state_r <= S_SCAN;
          end else if (dir_r == 2'd3) begin
            state_r <= S_OUT;
          end else begin
            dir_r <= dir_r + 2'd1;
            state_r <= S_ADD_RD;
          end
        end
        S_SCAN: begin
          if (idx_r >= cnt_r) state_r <= S_APPEND;
          else state_r <= S_SCANW;
        end
        S_SCANW: begin
          if (fr_rd_r == cand_key) begin
            if (dir_r == 2'd3) state_r <= S_OUT;
            else begin
              dir_r <= dir_r + 2'd1;
              state_r <= S_ADD_RD;
            end
          end else begin
            idx_r <= idx_r + 1'b1;
            state_r <= S_SCAN;
          end
        end
        S_APPEND: begin
          if (cnt_r < FC'(FRONTIER_DEPTH)) cnt_r <= cnt_r + 1'b1;
          if (dir_r == 2'd3) state_r <= S_OUT;
          else begin
            dir_r <= dir_r + 2'd1;
            state_r <= S_ADD_RD;
          end
        end
        S_OUT: if (!out_valid_r || out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // memory port control
  always_comb begin
    map_we = 1'b0;
    map_wa = '0;
    map_wd = CELL_OPEN;
    map_ra = maddr(nb_r, nb_c);
    fr_we  = 1'b0;
    fr_wa  = '0;
    fr_wd  = cand_key;
    fr_ra  = idx_r[FA-1:0];
    mreq.start    = 1'b0;
    mreq.dividend = in_r.rand_frontier;
    mreq.divisor  = 11'(cnt_r);
    unique case (state_r)
      S_IDLE: begin
        mreq.start = in_valid && in_data.action == ACT_STEP && cnt_r != '0;
        mreq.dividend = in_data.rand_frontier;
      end
      S_CLR: begin
        map_we = 1'b1;
        map_wa = clr_r[MA-1:0];
        map_wd = CELL_WALL;
      end
      S_SEED: begin
        map_we = 1'b1;
        map_wa = maddr(EW'(1), EW'(1));
      end
      S_SHIFT: fr_ra = FA'(idx_r + 1'b1);
      S_SHW: begin
        fr_we = 1'b1;
        fr_wa = idx_r[FA-1:0];
        fr_wd = fr_rd_r;
      end
      S_NB_EVAL: begin
        mreq.start = (dir_r == 2'd3);
        mreq.dividend = in_r.rand_neighbor;
        mreq.divisor = 11'(nbn_r) +
          11'(nb_ok && nb_in_map && map_rd_r == CELL_OPEN);
      end
      S_WALL: begin
        map_we = (((cur_r_r + nb_r) >> 1) < MAXR) && (((cur_c_r + nb_c) >> 1) < MAXC);
        map_wa = maddr((cur_r_r + nb_r) >> 1, (cur_c_r + nb_c) >> 1);
      end
      S_OPEN: begin
        map_we = (cur_r_r < MAXR) && (cur_c_r < MAXC);
        map_wa = maddr(cur_r_r, cur_c_r);
      end
      S_APPEND: begin
        fr_we = cnt_r < FC'(FRONTIER_DEPTH);
        fr_wa = cnt_r[FA-1:0];
      end
      default: ;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

// File: sv/rpmg_checker.sv
// port-level checker for the prim maze generator, bound to the top level
// depends on rpmg_pkg and random_prim_maze_generator_macros.svh
`default_nettype none
`include "random_prim_maze_generator_macros.svh"
module rpmg_checker
  import rpmg_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire out_word_t out_data,
  input wire logic      out_valid,
  input wire logic      out_ready
);
  `RPMG_ASSERT_IMP(a_done_empty, clk, rst_n, out_valid,
    out_data.done_res == (out_data.pending_count == 9'd0))
  `RPMG_ASSERT_IMP(a_wall_zero, clk, rst_n, out_valid && !out_data.wall_valid,
    out_data.wall_row == 5'd0 && out_data.wall_col == 5'd0)
  `RPMG_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready)
  `RPMG_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_data))
endmodule

bind random_prim_maze_generator rpmg_checker u_rpmg_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
);
`default_nettype wire

// File: bench/tb_random_prim_maze_generator.sv
// self-checking bench for the prim maze generator: directed, random and back-pressure runs
// depends on rpmg_pkg and random_prim_maze_generator; a behavioural maze model predicts each word
module tb_random_prim_maze_generator;
  import rpmg_pkg::*;

  localparam int MAXR = 32;
  localparam int MAXC = 32;
  localparam int FDEPTH = 256;
  localparam int CYCLE_LIMIT = 20000000;
  localparam int DRAIN_CYCLES = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_ROWS;
  logic [5:0] cfg_wdata = '0;

  random_prim_maze_generator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // maze model state, mirrors the block's map, frontier list and grid registers
  bit        maze_open [0:MAXR*MAXC-1];
  logic [4:0] front_row [0:FDEPTH-1];
  logic [4:0] front_col [0:FDEPTH-1];
  int        front_n;
  int        grid_rows_q;
  int        grid_cols_q;

  out_word_t carved_q [$];
  int        errors = 0;
  int        words_sent = 0;
  int        words_seen = 0;
  int        mazes_begun = 0;
  int        passless_steps = 0;
  int        cycles = 0;

  // sender burst shaping
  int burst_left = 0;
  // receiver long hold-off, counted down in the receiver process
  int hold_req = 0;

  function automatic int clamp_dim(int v, int maxv);
    if (v > maxv) v = maxv;
    if (v < 3) v = 3;
    return v;
  endfunction

  function automatic bit cell_at(int r, int c);
    if (r >= MAXR || c >= MAXC) return CELL_WALL;
    return maze_open[r*MAXC + c];
  endfunction

  // neighbours two away in left, right, up, down order whose map bit matches
  function automatic int near_cells(int r, int c, bit want, output int nr[4], output int nc[4]);
    int m, n, k;
    m = clamp_dim(grid_rows_q, MAXR);
    n = clamp_dim(grid_cols_q, MAXC);
    k = 0;
    if (c > 2 && cell_at(r, c-2) == want) begin nr[k] = r; nc[k] = c-2; k++; end
    if (c+2 < n && cell_at(r, c+2) == want) begin nr[k] = r; nc[k] = c+2; k++; end
    if (r > 2 && cell_at(r-2, c) == want) begin nr[k] = r-2; nc[k] = c; k++; end
    if (r+2 < m && cell_at(r+2, c) == want) begin nr[k] = r+2; nc[k] = c; k++; end
    return k;
  endfunction

  // append walled neighbours, no duplicates, drop when full
  function automatic void grow_frontier(int r, int c);
    int nr[4], nc[4], k;
    bit dup;
    k = near_cells(r, c, CELL_WALL, nr, nc);
    for (int i = 0; i < k; i++) begin
      dup = 0;
      for (int j = 0; j < front_n; j++)
        if (int'(front_row[j]) == nr[i] && int'(front_col[j]) == nc[i]) dup = 1;
      if (!dup && front_n < FDEPTH) begin
        front_row[front_n] = 5'(nr[i]);
        front_col[front_n] = 5'(nc[i]);
        front_n++;
      end
    end
  endfunction

  function automatic out_word_t carve_word(in_word_t w);
    out_word_t o;
    int idx, k, s, cr, cc, wr, wc;
    int nr[4], nc[4];
    o = '0;
    cr = 0; cc = 0; wr = 0; wc = 0;
    if (w.action == ACT_BEGIN) begin
      foreach (maze_open[i]) maze_open[i] = CELL_WALL;
      front_n = 0;
      maze_open[1*MAXC + 1] = CELL_OPEN;
      cr = 1; cc = 1;
      grow_frontier(1, 1);
    end else if (front_n > 0) begin
      idx = int'(w.rand_frontier) % front_n;
      cr = int'(front_row[idx]);
      cc = int'(front_col[idx]);
      for (int i = idx; i + 1 < front_n; i++) begin
        front_row[i] = front_row[i+1];
        front_col[i] = front_col[i+1];
      end
      front_n--;
      k = near_cells(cr, cc, CELL_OPEN, nr, nc);
      if (k > 0) begin
        s = int'(w.rand_neighbor) % k;
        wr = (cr + nr[s]) >> 1;
        wc = (cc + nc[s]) >> 1;
        o.wall_valid = 1'b1;
        if (wr < MAXR && wc < MAXC) maze_open[wr*MAXC + wc] = CELL_OPEN;
      end else begin
        passless_steps++;
      end
      if (cr < MAXR && cc < MAXC) maze_open[cr*MAXC + cc] = CELL_OPEN;
      grow_frontier(cr, cc);
    end
    o.cell_row = cr[4:0];
    o.cell_col = cc[4:0];
    o.wall_row = wr[4:0];
    o.wall_col = wc[4:0];
    o.pending_count = front_n[8:0];
    o.done_res = (front_n == 0);
    return o;
  endfunction

  // one word through the input channel, bursts with random gaps between them
  task automatic send_word(input logic act, input logic [15:0] rf, input logic [15:0] rn);
    in_word_t w;
    int gap;
    w.action = act;
    w.rand_frontier = rf;
    w.rand_neighbor = rn;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    // accepted at this edge
    carved_q.push_back(carve_word(w));
    words_sent++;
    if (act == ACT_BEGIN) mazes_begun++;
  endtask

  task automatic step_word();
    send_word(ACT_STEP, 16'($urandom), 16'($urandom));
  endtask

  // drain everything, then let the block settle before touching a register
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (carved_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [5:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ROWS) grid_rows_q = int'(val);
    else grid_cols_q = int'(val);
  endtask

  task automatic set_grid(input logic [5:0] r, input logic [5:0] c);
    write_reg(CFG_ROWS, r);
    write_reg(CFG_COLS, c);
  endtask

  // result checker, oldest expectation first
  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      words_seen++;
      if (carved_q.size() == 0) begin
        $display("%0t unexpected word: expected none actual %h", $time, out_data);
        errors++;
      end else begin
        e = carved_q.pop_front();
        check_field("cell_row", int'(e.cell_row), int'(out_data.cell_row));
        check_field("cell_col", int'(e.cell_col), int'(out_data.cell_col));
        check_field("wall_valid", int'(e.wall_valid), int'(out_data.wall_valid));
        check_field("wall_row", int'(e.wall_row), int'(out_data.wall_row));
        check_field("wall_col", int'(e.wall_col), int'(out_data.wall_col));
        check_field("pending_count", int'(e.pending_count), int'(out_data.pending_count));
        check_field("done_res", int'(e.done_res), int'(out_data.done_res));
      end
    end
  end

  // receiver: stall pattern changes by epoch, plus an occasional long hold-off
  int ready_mode = 0;
  int epoch_left = 0;
  always @(posedge clk) begin
    if (epoch_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      epoch_left <= $urandom_range(200, 6000);
    end else begin
      epoch_left <= epoch_left - 1;
    end
    if (hold_req > 0) begin
      hold_req <= hold_req - 1;
      out_ready <= 1'b0;
    end else begin
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 7) == 0);
        default: out_ready <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, carved_q.size());
      $display("tb_random_prim_maze_generator NOT OK");
      $finish;
    end
  end

  // extremes of fields, empty frontier, tiny and clamped grids
  task automatic test_directed();
    send_word(ACT_STEP, 16'hffff, 16'hffff);   // step before any begin
    send_word(ACT_BEGIN, 16'h0000, 16'h0000);
    send_word(ACT_STEP, 16'h0000, 16'h0000);
    send_word(ACT_STEP, 16'hffff, 16'hffff);
    send_word(ACT_STEP, 16'h5555, 16'haaaa);
    send_word(ACT_BEGIN, 16'hffff, 16'hffff);  // restart mid-maze
    step_word();
    set_grid(6'd3, 6'd3);                      // smallest grid: frontier empty at once
    send_word(ACT_BEGIN, 16'h1234, 16'h4321);
    send_word(ACT_STEP, 16'hffff, 16'h0000);
    set_grid(6'd0, 6'd63);                     // below and above the clamp
    send_word(ACT_BEGIN, 16'h0000, 16'hffff);
    repeat (5) step_word();
    set_grid(6'd63, 6'd0);
    send_word(ACT_BEGIN, 16'h0000, 16'h0000);
    repeat (3) step_word();
    // shrink the grid under a live maze so some taken cells have no open neighbour
    set_grid(6'd32, 6'd32);
    send_word(ACT_BEGIN, 16'h0000, 16'h0000);
    repeat (4) send_word(ACT_STEP, 16'hffff, 16'h0000);
    set_grid(6'd3, 6'd3);
    repeat (3) step_word();
  endtask

  // mostly whole mazes on small grids, some noise and mid-maze grid changes
  task automatic test_random();
    int target, steps, sel;
    logic [5:0] r, c;
    target = words_sent + 1000;
    while (words_sent < target) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        r = 6'($urandom); c = 6'($urandom);
      end else if (sel == 1) begin
        r = 6'd32; c = 6'd32;
      end else begin
        r = 6'($urandom_range(3, 13)); c = 6'($urandom_range(3, 13));
      end
      set_grid(r, c);
      send_word(ACT_BEGIN, 16'($urandom), 16'($urandom));
      steps = (sel == 1) ? $urandom_range(20, 80) : $urandom_range(5, 60);
      for (int i = 0; i < steps; i++) begin
        if ($urandom_range(0, 49) == 0) send_word(1'($urandom_range(0, 1)), 16'($urandom),
                                                  16'($urandom));
        else step_word();
        if ($urandom_range(0, 99) == 0) begin
          // change the grid under a live maze
          set_grid(6'($urandom_range(3, 13)), 6'($urandom_range(3, 13)));
        end
      end
    end
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    set_grid(6'd21, 6'd31);
    send_word(ACT_BEGIN, 16'h0000, 16'h0000);
    settle();
    hold_req = 8000;
    burst_left = 40;
    repeat (6) step_word();
  endtask

  initial begin
    foreach (maze_open[i]) maze_open[i] = CELL_WALL;
    front_n = 0;
    grid_rows_q = int'(ROWS_RESET);
    grid_cols_q = int'(COLS_RESET);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d words over %0d mazes, %0d steps carved without a passage",
             words_sent, mazes_begun, passless_steps);
    $display("checked %0d result words in %0d cycles, %0d mismatches",
             words_seen, cycles, errors);
    if (errors == 0 && carved_q.size() == 0) begin
      $display("tb_random_prim_maze_generator OK");
    end else begin
      $display("tb_random_prim_maze_generator NOT OK");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+sv
sv/rpmg_pkg.sv
sv/rpmg_mod_unit.sv
sv/random_prim_maze_generator.sv
sv/rpmg_checker.sv
bench/tb_random_prim_maze_generator.sv
